[rtl/acx_pkg.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU execute package
// Shared sizes, opcode codes, decoded instruction and result types.
// ----------------------------------------------------------------------------
package acx_pkg;

    localparam int NUM_REGS   = 8;
    localparam int DATA_DEPTH = 16;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int MEM_IDX_W  = $clog2(DATA_DEPTH);
    localparam int DATA_W     = 8;
    localparam int PC_W       = 8;
    localparam int LEN_W      = 9;
    localparam int OPC_W      = 4;
    localparam int OPND_W     = 4;

    localparam logic [LEN_W-1:0] PROG_LEN_RESET = 9'd256;

    localparam int IQ_DEPTH  = 2;
    localparam int IQ_PTR_W  = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W  = $clog2(IQ_DEPTH + 1);
    localparam int RQ_DEPTH  = 2;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    localparam logic [OPC_W-1:0] OPC_ADD   = 4'd1;
    localparam logic [OPC_W-1:0] OPC_SUB   = 4'd2;
    localparam logic [OPC_W-1:0] OPC_LOAD  = 4'd3;
    localparam logic [OPC_W-1:0] OPC_STORE = 4'd4;
    localparam logic [OPC_W-1:0] OPC_JMP   = 4'd5;
    localparam logic [OPC_W-1:0] OPC_JZ    = 4'd6;
    localparam logic [OPC_W-1:0] OPC_JNZ   = 4'd7;
    localparam logic [OPC_W-1:0] OPC_IN    = 4'd8;
    localparam logic [OPC_W-1:0] OPC_OUT   = 4'd9;
    localparam logic [OPC_W-1:0] OPC_HLT   = 4'd10;

    typedef enum logic [3:0] {
        K_BAD,
        K_ADD,
        K_SUB,
        K_LOAD,
        K_STORE,
        K_JMP,
        K_JZ,
        K_JNZ,
        K_IN,
        K_OUT,
        K_HLT
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [OPND_W-1:0]   operand;
        logic [DATA_W-1:0]   in_value;
    } t_instr;

    typedef struct packed {
        logic [PC_W-1:0]     next_pc;
        logic                out_valid;
        logic [DATA_W-1:0]   out_value;
        logic                halted;
        logic                bad_opcode;
        logic                program_done;
    } t_result;

endpackage

[rtl/acx_front.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU front end
// Accepts instruction transactions and decodes the opcode into a class.
// ----------------------------------------------------------------------------
module acx_front (
    input  logic                       i_push,
    input  logic                       i_iq_full,
    input  logic [acx_pkg::OPC_W-1:0]  i_func,
    input  logic [acx_pkg::OPND_W-1:0] i_operand,
    input  logic [acx_pkg::DATA_W-1:0] i_in_value,
    output logic                       o_iq_wr,
    output acx_pkg::t_instr            o_instr
);

    acx_pkg::t_kind kind;

    always_comb begin
        unique case (i_func)
            acx_pkg::OPC_ADD:   kind = acx_pkg::K_ADD;
            acx_pkg::OPC_SUB:   kind = acx_pkg::K_SUB;
            acx_pkg::OPC_LOAD:  kind = acx_pkg::K_LOAD;
            acx_pkg::OPC_STORE: kind = acx_pkg::K_STORE;
            acx_pkg::OPC_JMP:   kind = acx_pkg::K_JMP;
            acx_pkg::OPC_JZ:    kind = acx_pkg::K_JZ;
            acx_pkg::OPC_JNZ:   kind = acx_pkg::K_JNZ;
            acx_pkg::OPC_IN:    kind = acx_pkg::K_IN;
            acx_pkg::OPC_OUT:   kind = acx_pkg::K_OUT;
            acx_pkg::OPC_HLT:   kind = acx_pkg::K_HLT;
            default:            kind = acx_pkg::K_BAD;
        endcase
    end

    assign o_iq_wr          = i_push && !i_iq_full;
    assign o_instr.kind     = kind;
    assign o_instr.operand  = i_operand;
    assign o_instr.in_value = i_in_value;

endmodule

[rtl/acx_iq.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU instruction queue
// Small register queue of decoded instructions between front and back end.
// ----------------------------------------------------------------------------
module acx_iq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  acx_pkg::t_instr i_instr,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output acx_pkg::t_instr o_instr
);

    acx_pkg::t_instr                  r_mem [acx_pkg::IQ_DEPTH];
    logic [acx_pkg::IQ_PTR_W-1:0]     r_wptr;
    logic [acx_pkg::IQ_PTR_W-1:0]     r_rptr;
    logic [acx_pkg::IQ_CNT_W-1:0]     r_cnt;
    logic [acx_pkg::IQ_CNT_W-1:0]     n_cnt;
    logic                             rd_fire;

    assign o_full  = (r_cnt == acx_pkg::IQ_CNT_W'(acx_pkg::IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_instr = r_mem[r_rptr];
    assign rd_fire = i_rd && o_valid;

    always_comb begin
        n_cnt = r_cnt + acx_pkg::IQ_CNT_W'(i_wr) - acx_pkg::IQ_CNT_W'(rd_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_fire) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_instr;
        end
    end

endmodule

[rtl/acx_back.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU back end
// Executes one decoded instruction per cycle, while the result queue has room,
// against the machine state and queues the result transaction.
// ----------------------------------------------------------------------------
module acx_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [acx_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                       i_iq_valid,
    input  acx_pkg::t_instr            i_instr,
    output logic                       o_iq_rd,
    input  logic                       i_pop,
    output logic                       o_empty,
    output acx_pkg::t_result           o_result
);

    logic [acx_pkg::LEN_W-1:0]    r_len;
    logic [acx_pkg::DATA_W-1:0]   r_regs [acx_pkg::NUM_REGS];
    logic [acx_pkg::DATA_W-1:0]   r_dmem [acx_pkg::DATA_DEPTH];
    logic [acx_pkg::PC_W-1:0]     r_pc;
    logic                         r_halt;

    acx_pkg::t_result             r_rq [acx_pkg::RQ_DEPTH];
    logic [acx_pkg::RQ_PTR_W-1:0] r_rq_head;
    logic [acx_pkg::RQ_CNT_W-1:0] r_rq_cnt;

    logic [acx_pkg::PC_W-1:0]     n_pc;
    logic                         n_halt;
    logic [acx_pkg::RQ_CNT_W-1:0] n_rq_cnt;

    logic                         go;
    logic                         rq_pop;
    logic                         rq_space;
    logic                         active;
    logic [acx_pkg::REG_IDX_W-1:0] ri;
    logic [acx_pkg::MEM_IDX_W-1:0] mi;
    logic [acx_pkg::DATA_W-1:0]   acc;
    logic [acx_pkg::DATA_W-1:0]   rval;
    logic                         reg_we;
    logic [acx_pkg::REG_IDX_W-1:0] reg_widx;
    logic [acx_pkg::DATA_W-1:0]   reg_wdata;
    logic                         mem_we;
    logic [acx_pkg::RQ_PTR_W-1:0] rq_tail;
    acx_pkg::t_result             res;

    assign o_empty  = (r_rq_cnt == '0);
    assign o_result = r_rq[r_rq_head];
    assign rq_pop   = i_pop && !o_empty;
    assign rq_space = (r_rq_cnt != acx_pkg::RQ_CNT_W'(acx_pkg::RQ_DEPTH)) || rq_pop;
    assign go       = i_iq_valid && rq_space;
    assign o_iq_rd  = go;

    assign ri     = i_instr.operand[acx_pkg::REG_IDX_W-1:0];
    assign mi     = i_instr.operand[acx_pkg::MEM_IDX_W-1:0];
    assign acc    = r_regs[0];
    assign rval   = r_regs[ri];
    assign active = !r_halt && ({1'b0, r_pc} < r_len);
    assign rq_tail = r_rq_head + r_rq_cnt[acx_pkg::RQ_PTR_W-1:0];

    always_comb begin
        n_pc      = r_pc;
        n_halt    = r_halt;
        reg_we    = 1'b0;
        reg_widx  = '0;
        reg_wdata = acc;
        mem_we    = 1'b0;
        res       = '0;
        if (active) begin
            n_pc = r_pc + 1'b1;
            unique case (i_instr.kind)
                acx_pkg::K_ADD: begin
                    reg_we    = 1'b1;
                    reg_wdata = acc + rval;
                end
                acx_pkg::K_SUB: begin
                    reg_we    = 1'b1;
                    reg_wdata = acc - rval;
                end
                acx_pkg::K_LOAD: begin
                    reg_we    = 1'b1;
                    reg_wdata = r_dmem[mi];
                end
                acx_pkg::K_STORE: begin
                    mem_we = 1'b1;
                end
                acx_pkg::K_JMP: begin
                    n_pc = acx_pkg::PC_W'(i_instr.operand);
                end
                acx_pkg::K_JZ: begin
                    if (acc == '0) begin
                        n_pc = acx_pkg::PC_W'(i_instr.operand);
                    end
                end
                acx_pkg::K_JNZ: begin
                    if (acc != '0) begin
                        n_pc = acx_pkg::PC_W'(i_instr.operand);
                    end
                end
                acx_pkg::K_IN: begin
                    reg_we    = 1'b1;
                    reg_widx  = ri;
                    reg_wdata = i_instr.in_value;
                end
                acx_pkg::K_OUT: begin
                    res.out_valid = 1'b1;
                    res.out_value = rval;
                end
                acx_pkg::K_HLT: begin
                    n_halt = 1'b1;
                end
                acx_pkg::K_BAD: begin
                    res.bad_opcode = 1'b1;
                end
                default: begin
                    res.bad_opcode = 1'b1;
                end
            endcase
        end
        res.next_pc      = n_pc;
        res.halted       = n_halt;
        res.program_done = ({1'b0, n_pc} >= r_len);
    end

    always_comb begin
        n_rq_cnt = r_rq_cnt + acx_pkg::RQ_CNT_W'(go) - acx_pkg::RQ_CNT_W'(rq_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= acx_pkg::PROG_LEN_RESET;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_rq_head <= '0;
            r_rq_cnt  <= '0;
            for (int i = 0; i < acx_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            for (int j = 0; j < acx_pkg::DATA_DEPTH; j++) begin
                r_dmem[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (go) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
                if (reg_we) begin
                    r_regs[reg_widx] <= reg_wdata;
                end
                if (mem_we) begin
                    r_dmem[mi] <= acc;
                end
            end
            if (rq_pop) begin
                r_rq_head <= r_rq_head + 1'b1;
            end
            r_rq_cnt <= n_rq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rq[rq_tail] <= res;
        end
    end

endmodule

[rtl/accumulator_cpu_execute.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU execute stage
// Executes one instruction transaction per cycle for a small accumulator
// machine while the result queue has room; each gives one result transaction.
//
// Input channel: the instruction (i_func, i_operand, i_in_value) is taken on
// a rising edge with push high and full low. Result channel: the oldest
// result sits on the o_ ports while empty is low and leaves on a rising edge
// with pop high. The one configuration register (program length) is written
// through i_cfg_we / i_cfg_wdata while the block is idle, a rule the user
// must keep: the block does not enforce it. An accepted instruction waits in
// the instruction queue, its result in the result queue that drives the
// ports. Execute takes one instruction per cycle while the result queue has
// room, and reads and writes the register file and data bytes. Two-entry
// queues sit between decode and execute and after execute, so push is taken
// while a finished result still waits. When the receiver stalls, the result
// queue fills, execute holds, and full rises after two more instructions.
// Synchronous reset clears both queues, the registers, the data bytes, the
// program counter and the halt flag, and sets the program length to 256.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [acx_pkg::OPC_W-1:0]  i_func,
    input  logic [acx_pkg::OPND_W-1:0] i_operand,
    input  logic [acx_pkg::DATA_W-1:0] i_in_value,
    output logic                       empty,
    input  logic                       pop,
    output logic [acx_pkg::PC_W-1:0]   o_next_pc,
    output logic                       o_out_valid,
    output logic [acx_pkg::DATA_W-1:0] o_out_value,
    output logic                       o_halted,
    output logic                       o_bad_opcode,
    output logic                       o_program_done,
    input  logic                       i_cfg_we,
    input  logic [acx_pkg::LEN_W-1:0]  i_cfg_wdata
);

    logic             iq_wr;
    logic             iq_rd;
    logic             iq_valid;
    acx_pkg::t_instr  dec_instr;
    acx_pkg::t_instr  iq_instr;
    acx_pkg::t_result result;

    acx_front u_front (
        .i_push     (push),
        .i_iq_full  (full),
        .i_func     (i_func),
        .i_operand  (i_operand),
        .i_in_value (i_in_value),
        .o_iq_wr    (iq_wr),
        .o_instr    (dec_instr)
    );

    acx_iq u_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (iq_wr),
        .i_instr (dec_instr),
        .i_rd    (iq_rd),
        .o_full  (full),
        .o_valid (iq_valid),
        .o_instr (iq_instr)
    );

    acx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_iq_valid  (iq_valid),
        .i_instr     (iq_instr),
        .o_iq_rd     (iq_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_next_pc      = result.next_pc;
    assign o_out_valid    = result.out_valid;
    assign o_out_value    = result.out_value;
    assign o_halted       = result.halted;
    assign o_bad_opcode   = result.bad_opcode;
    assign o_program_done = result.program_done;

endmodule

[rtl/acx_checker.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU execute checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module acx_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       full,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [acx_pkg::PC_W-1:0]   o_next_pc,
    input  logic                       o_out_valid,
    input  logic [acx_pkg::DATA_W-1:0] o_out_value,
    input  logic                       o_halted,
    input  logic                       o_bad_opcode
);

    // After reset both queues are drained.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A result that did not execute OUT reports zero.
    a_out_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_valid) |-> (o_out_value == '0))
        else $error("out_value nonzero without OUT");

    // A halted result never reports output or a bad opcode.
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_halted) |-> (!o_out_valid && !o_bad_opcode))
        else $error("halted result carries output or bad opcode");

    // A bad opcode never produces output.
    a_bad_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_opcode) |-> !o_out_valid)
        else $error("bad opcode with output");

    // A result that is not taken stays available.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_next_pc) && $stable(o_halted)))
        else $error("waiting result lost");

endmodule

bind accumulator_cpu_execute acx_checker u_acx_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator CPU execute stage testbench
// Drives instruction transactions through the push/full queue interface and
// drains result transactions through empty/pop. A scoreboard class tracks
// the register file, data bytes, program counter, halt flag and program
// length, predicts each result, and compares it field by field. A short
// directed sequence is followed by one long phase that wraps the program
// counter, random program phases with varied program lengths, and a
// final halt.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [acx_pkg::OPC_W-1:0] OPC_BAD_ZERO  = 4'd0;
    localparam logic [acx_pkg::OPC_W-1:0] OPC_BAD_FIRST = 4'd11;
    localparam logic [acx_pkg::OPC_W-1:0] OPC_BAD_LAST  = 4'd15;

    localparam int ITEM_TARGET  = 1100;
    localparam int IDLE_PCT     = 18;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    class acc_machine_scoreboard;
        logic [acx_pkg::NUM_REGS-1:0][acx_pkg::DATA_W-1:0]   regs;
        logic [acx_pkg::DATA_DEPTH-1:0][acx_pkg::DATA_W-1:0] data_bytes;
        logic [acx_pkg::PC_W-1:0]                            pc;
        logic                                                halt;
        logic [acx_pkg::LEN_W-1:0]                           prog_len;
        acx_pkg::t_result                                    expected_results[$];
        int                                                  accepted;
        int                                                  mismatches;

        function new();
            regs       = '0;
            data_bytes = '0;
            pc         = '0;
            halt       = 1'b0;
            prog_len   = acx_pkg::PROG_LEN_RESET;
            accepted   = 0;
            mismatches = 0;
        endfunction

        function void set_program_length(input logic [acx_pkg::LEN_W-1:0] len);
            prog_len = len;
        endfunction

        function void predict_instr(input logic [acx_pkg::OPC_W-1:0] func,
                                    input logic [acx_pkg::OPND_W-1:0] operand,
                                    input logic [acx_pkg::DATA_W-1:0] in_value);
            acx_pkg::t_result                r;
            logic [acx_pkg::PC_W-1:0]        npc;
            logic [acx_pkg::REG_IDX_W-1:0]   ri;
            r  = '0;
            ri = operand[acx_pkg::REG_IDX_W-1:0];
            if (!halt && {1'b0, pc} < prog_len) begin
                npc = pc + 8'd1;
                case (func)
                    acx_pkg::OPC_ADD: begin
                        regs[0] = regs[0] + regs[ri];
                    end
                    acx_pkg::OPC_SUB: begin
                        regs[0] = regs[0] - regs[ri];
                    end
                    acx_pkg::OPC_LOAD: begin
                        regs[0] = data_bytes[operand];
                    end
                    acx_pkg::OPC_STORE: begin
                        data_bytes[operand] = regs[0];
                    end
                    acx_pkg::OPC_JMP: begin
                        npc = {4'b0, operand};
                    end
                    acx_pkg::OPC_JZ: begin
                        if (regs[0] == '0) npc = {4'b0, operand};
                    end
                    acx_pkg::OPC_JNZ: begin
                        if (regs[0] != '0) npc = {4'b0, operand};
                    end
                    acx_pkg::OPC_IN: begin
                        regs[ri] = in_value;
                    end
                    acx_pkg::OPC_OUT: begin
                        r.out_valid = 1'b1;
                        r.out_value = regs[ri];
                    end
                    acx_pkg::OPC_HLT: begin
                        halt = 1'b1;
                    end
                    default: begin
                        r.bad_opcode = 1'b1;
                    end
                endcase
                pc = npc;
            end
            accepted++;
            r.next_pc      = pc;
            r.halted       = halt;
            r.program_done = ({1'b0, pc} >= prog_len);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_val,
                                    input logic [7:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(input acx_pkg::t_result got);
            acx_pkg::t_result exp_r;
            if (expected_results.size() == 0) begin
                $error("result transaction arrived with no instruction outstanding");
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("next_pc", exp_r.next_pc, got.next_pc);
            compare_field("out_valid", 8'(exp_r.out_valid), 8'(got.out_valid));
            compare_field("out_value", exp_r.out_value, got.out_value);
            compare_field("halted", 8'(exp_r.halted), 8'(got.halted));
            compare_field("bad_opcode", 8'(exp_r.bad_opcode), 8'(got.bad_opcode));
            compare_field("program_done", 8'(exp_r.program_done),
                          8'(got.program_done));
        endfunction
    endclass

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         push           = 1'b0;
    logic                         full;
    logic [acx_pkg::OPC_W-1:0]    i_func         = '0;
    logic [acx_pkg::OPND_W-1:0]   i_operand      = '0;
    logic [acx_pkg::DATA_W-1:0]   i_in_value     = '0;
    logic                         empty;
    logic                         pop            = 1'b0;
    logic [acx_pkg::PC_W-1:0]     o_next_pc;
    logic                         o_out_valid;
    logic [acx_pkg::DATA_W-1:0]   o_out_value;
    logic                         o_halted;
    logic                         o_bad_opcode;
    logic                         o_program_done;
    logic                         i_cfg_we       = 1'b0;
    logic [acx_pkg::LEN_W-1:0]    i_cfg_wdata    = '0;

    logic              calm           = 1'b0;
    logic              hold_request   = 1'b0;
    int                hold_left      = 0;
    bit                hold_taken     = 1'b0;
    int                cycle_count    = 0;

    acc_machine_scoreboard sb = new();

    accumulator_cpu_execute dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_operand      (i_operand),
        .i_in_value     (i_in_value),
        .empty          (empty),
        .pop            (pop),
        .o_next_pc      (o_next_pc),
        .o_out_valid    (o_out_valid),
        .o_out_value    (o_out_value),
        .o_halted       (o_halted),
        .o_bad_opcode   (o_bad_opcode),
        .o_program_done (o_program_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Result side: check every popped transaction, then decide the next pop.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result({o_next_pc, o_out_valid, o_out_value, o_halted,
                             o_bad_opcode, o_program_done});
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_instr(input logic [acx_pkg::OPC_W-1:0] func,
                              input logic [acx_pkg::OPND_W-1:0] operand,
                              input logic [acx_pkg::DATA_W-1:0] in_value);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_func     <= func;
        i_operand  <= operand;
        i_in_value <= in_value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.predict_instr(func, operand, in_value);
    endtask

    task automatic send_random(input bit allow_jumps);
        logic [acx_pkg::OPC_W-1:0]  func;
        logic [acx_pkg::DATA_W-1:0] in_value;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) func = acx_pkg::OPC_ADD;
        else if (pick < 24) func = acx_pkg::OPC_SUB;
        else if (pick < 36) func = acx_pkg::OPC_LOAD;
        else if (pick < 48) func = acx_pkg::OPC_STORE;
        else if (pick < 62) func = acx_pkg::OPC_IN;
        else if (pick < 76) func = acx_pkg::OPC_OUT;
        else if (pick < 82) func = allow_jumps ? acx_pkg::OPC_JMP : acx_pkg::OPC_ADD;
        else if (pick < 88) func = allow_jumps ? acx_pkg::OPC_JZ : acx_pkg::OPC_SUB;
        else if (pick < 94) func = allow_jumps ? acx_pkg::OPC_JNZ : acx_pkg::OPC_OUT;
        else if (pick < 96) func = OPC_BAD_ZERO;
        else func = 4'($urandom_range(OPC_BAD_FIRST, OPC_BAD_LAST));
        pick = $urandom_range(0, 9);
        if (pick == 0) in_value = '0;
        else if (pick == 1) in_value = '1;
        else in_value = 8'($urandom_range(0, 255));
        send_instr(func, 4'($urandom_range(0, 15)), in_value);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_program_length(input logic [acx_pkg::LEN_W-1:0] len);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_program_length(len);
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int                        n_items;
        int                        pick;
        int                        top;
        logic [acx_pkg::LEN_W-1:0] len;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: wrap-around arithmetic, taken and untaken branches,
        // register index folding, memory round trip and bad opcodes.
        send_instr(acx_pkg::OPC_IN, 4'd8, 8'hFF);
        send_instr(acx_pkg::OPC_IN, 4'd15, 8'h01);
        send_instr(acx_pkg::OPC_ADD, 4'd7, 8'h00);
        send_instr(acx_pkg::OPC_JZ, 4'd9, 8'h00);
        send_instr(acx_pkg::OPC_JNZ, 4'd3, 8'h00);
        send_instr(acx_pkg::OPC_SUB, 4'd15, 8'h00);
        send_instr(acx_pkg::OPC_STORE, 4'd15, 8'h00);
        send_instr(acx_pkg::OPC_LOAD, 4'd0, 8'h00);
        send_instr(acx_pkg::OPC_JNZ, 4'd2, 8'h00);
        send_instr(acx_pkg::OPC_LOAD, 4'd15, 8'h00);
        send_instr(acx_pkg::OPC_JNZ, 4'd2, 8'h00);
        send_instr(acx_pkg::OPC_OUT, 4'd0, 8'h00);
        send_instr(acx_pkg::OPC_OUT, 4'd15, 8'h00);
        send_instr(acx_pkg::OPC_IN, 4'd1, 8'h80);
        send_instr(acx_pkg::OPC_OUT, 4'd9, 8'h00);
        send_instr(OPC_BAD_ZERO, 4'd0, 8'h00);
        send_instr(OPC_BAD_FIRST, 4'd5, 8'h55);
        send_instr(OPC_BAD_LAST, 4'd15, 8'hFF);
        send_instr(acx_pkg::OPC_JMP, 4'd15, 8'h00);
        send_instr(acx_pkg::OPC_JMP, 4'd0, 8'h00);
        send_instr(acx_pkg::OPC_STORE, 4'd0, 8'h00);
        send_instr(acx_pkg::OPC_IN, 4'd0, 8'h00);
        send_instr(acx_pkg::OPC_JZ, 4'd6, 8'h00);

        // A zero-length program ignores everything; a short one runs out.
        write_program_length(9'd0);
        send_instr(acx_pkg::OPC_IN, 4'd0, 8'h12);
        send_instr(acx_pkg::OPC_OUT, 4'd0, 8'h00);
        write_program_length(9'd256);
        send_instr(acx_pkg::OPC_JMP, 4'd0, 8'h00);
        write_program_length(9'd2);
        send_instr(acx_pkg::OPC_IN, 4'd2, 8'h34);
        send_instr(acx_pkg::OPC_ADD, 4'd2, 8'h00);
        send_instr(acx_pkg::OPC_OUT, 4'd2, 8'h00);

        // Long straight-line run that wraps the program counter. The receiver
        // holds off once so the block fills, and a middle stretch runs without gaps.
        write_program_length(9'd256);
        send_instr(acx_pkg::OPC_JMP, 4'd0, 8'h00);
        for (int i = 0; i < 262; i++) begin
            if (i == 40) hold_request <= 1'b1;
            if (i == 120) calm <= 1'b1;
            if (i == 240) calm <= 1'b0;
            send_random(1'b0);
        end

        while (sb.accepted < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            top  = sb.pc + 48;
            if (top > 256) top = 256;
            if (pick == 0) len = 9'd0;
            else if (pick == 1) len = 9'd1;
            else if (pick == 2) len = 9'd256;
            else if (pick == 3) len = 9'd255;
            else if (pick == 4) len = 9'd16;
            else if (pick == 5) len = 9'd17;
            else len = 9'($urandom_range(sb.pc + 1, top));
            write_program_length(len);
            n_items = (len < 9'd2) ? 4 : $urandom_range(20, 120);
            repeat (n_items) send_random(1'b1);
        end

        // Halt: later items, including bad opcodes, change nothing.
        write_program_length(9'd256);
        repeat (5) send_random(1'b1);
        send_instr(acx_pkg::OPC_HLT, 4'd0, 8'h00);
        repeat (20) send_random(1'b1);
        send_instr(acx_pkg::OPC_HLT, 4'd3, 8'h00);
        write_program_length(9'd0);
        repeat (5) send_random(1'b1);

        wait_idle();
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
